FILE: hw/rtl/mtd_pkg.sv
package mtd_pkg;

	localparam int BYTE_W    = 8;
	localparam int MODE_W    = 2;
	localparam int SLOTS     = 4;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);
	localparam int ACC_W     = 18;
	localparam int SEXTET_W  = 6;

	localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_QP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_B64  = 2'd2;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_EQ   = 2'd1;
	localparam logic [1:0] PH_HI   = 2'd2;

	localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3d;
	localparam logic [BYTE_W-1:0] CH_NL    = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
	localparam logic [BYTE_W-1:0] CH_US    = 8'h5f;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2f;

	typedef struct packed {
		logic [SLOTS-1:0][BYTE_W-1:0] bytes;
		logic [CNT_W-1:0]             cnt;
		logic                         fin;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t item;
	} head_t;

	function automatic logic [3:0] hex_nib(input logic [BYTE_W-1:0] c);
		logic [3:0] r;
		r = 4'd0;
		if (c >= "0" && c <= "9") begin
			r = 4'(c - "0");
		end else if (c >= "A" && c <= "F") begin
			r = 4'(c - "A" + 8'd10);
		end else if (c >= "a" && c <= "f") begin
			r = 4'(c - "a" + 8'd10);
		end
		return r;
	endfunction

	function automatic logic [SEXTET_W-1:0] sextet_of(input logic [BYTE_W-1:0] c);
		logic [SEXTET_W-1:0] r;
		r = '0;
		if (c >= "A" && c <= "Z") begin
			r = SEXTET_W'(c - "A");
		end else if (c >= "a" && c <= "z") begin
			r = SEXTET_W'(c - "a" + 8'd26);
		end else if (c >= "0" && c <= "9") begin
			r = SEXTET_W'(c - "0" + 8'd52);
		end else if (c == CH_PLUS) begin
			r = 6'd62;
		end else if (c == CH_SLASH) begin
			r = 6'd63;
		end
		return r;
	endfunction

	function automatic logic is_ws(input logic [BYTE_W-1:0] c);
		return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [BYTE_W-1:0] qp_plain(input logic [BYTE_W-1:0] c);
		return (c == CH_US) ? CH_SP : c;
	endfunction

endpackage

FILE: hw/rtl/mtd_in_if.sv
interface mtd_in_if;
	logic       valid;
	logic       ready;
	logic       has_byte;
	logic [7:0] in_byte;
	logic       body_end;

	modport source (output valid, has_byte, in_byte, body_end, input ready);
	modport sink (input valid, has_byte, in_byte, body_end, output ready);
endinterface

FILE: hw/rtl/mtd_out_if.sv
interface mtd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       end_of_body;

	modport source (output valid, out_byte, last_of_run, end_of_body, input ready);
	modport sink (input valid, out_byte, last_of_run, end_of_body, output ready);
endinterface

FILE: hw/rtl/mtd_front.sv
module mtd_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_wdata,
	mtd_in_if.sink                   body,
	input  logic                     full,
	output logic                     push,
	output mtd_pkg::bundle_t         bundle
);
	import mtd_pkg::*;

	logic [MODE_W-1:0]   mode_q;
	logic [1:0]          quad_q, quad_d;
	logic [ACC_W-1:0]    accum_q, accum_d;
	logic [1:0]          pad_q, pad_d;
	logic [1:0]          phase_q, phase_d;
	logic [BYTE_W-1:0]   hi_q, hi_d;
	logic                accept;
	bundle_t             bnd;
	logic [SEXTET_W-1:0] sx;
	logic [23:0]         full_word;
	logic [CNT_W-1:0]    n_out;

	assign body.ready = !full;
	assign accept     = body.valid && !full;
	assign sx         = sextet_of(body.in_byte);

	always_comb begin
		bnd       = '0;
		quad_d    = quad_q;
		accum_d   = accum_q;
		pad_d     = pad_q;
		phase_d   = phase_q;
		hi_d      = hi_q;
		full_word = '0;
		n_out     = '0;
		bnd.fin   = body.body_end;
		case (mode_q)
			MODE_QP: begin
				if (body.has_byte) begin
					if (phase_q == PH_EQ) begin
						if (body.in_byte == CH_NL) begin
							phase_d = PH_IDLE;
						end else begin
							hi_d    = body.in_byte;
							phase_d = PH_HI;
						end
					end else if (phase_q == PH_HI) begin
						bnd.bytes[bnd.cnt[SLOT_W-1:0]] = {hex_nib(hi_q), hex_nib(body.in_byte)};
						bnd.cnt = bnd.cnt + 1'b1;
						phase_d = PH_IDLE;
					end else if (body.in_byte == CH_EQ) begin
						phase_d = PH_EQ;
					end else begin
						bnd.bytes[bnd.cnt[SLOT_W-1:0]] = qp_plain(body.in_byte);
						bnd.cnt = bnd.cnt + 1'b1;
					end
				end
				if (body.body_end) begin
					if (phase_d == PH_EQ) begin
						bnd.bytes[bnd.cnt[SLOT_W-1:0]] = CH_EQ;
						bnd.cnt = bnd.cnt + 1'b1;
					end else if (phase_d == PH_HI) begin
						bnd.bytes[bnd.cnt[SLOT_W-1:0]] = CH_EQ;
						bnd.cnt = bnd.cnt + 1'b1;
						bnd.bytes[bnd.cnt[SLOT_W-1:0]] = qp_plain(hi_d);
						bnd.cnt = bnd.cnt + 1'b1;
					end
					phase_d = PH_IDLE;
					hi_d    = '0;
				end
			end
			MODE_B64: begin
				if (body.has_byte && !(quad_q == 2'd0 && is_ws(body.in_byte))) begin
					if (quad_q != 2'd0 && body.in_byte == CH_EQ) begin
						pad_d = pad_q + 2'd1;
					end
					if (quad_q != 2'd3) begin
						accum_d = {accum_q[ACC_W-SEXTET_W-1:0], sx};
						quad_d  = quad_q + 2'd1;
					end else begin
						full_word = {accum_q, sx};
						n_out     = CNT_W'(3) - {1'b0, pad_d};
						if (n_out >= CNT_W'(1)) begin
							bnd.bytes[bnd.cnt[SLOT_W-1:0]] = full_word[23:16];
							bnd.cnt = bnd.cnt + 1'b1;
						end
						if (n_out >= CNT_W'(2)) begin
							bnd.bytes[bnd.cnt[SLOT_W-1:0]] = full_word[15:8];
							bnd.cnt = bnd.cnt + 1'b1;
						end
						if (n_out >= CNT_W'(3)) begin
							bnd.bytes[bnd.cnt[SLOT_W-1:0]] = full_word[7:0];
							bnd.cnt = bnd.cnt + 1'b1;
						end
						quad_d  = '0;
						accum_d = '0;
						pad_d   = '0;
					end
				end
				if (body.body_end) begin
					quad_d  = '0;
					accum_d = '0;
					pad_d   = '0;
					bnd.bytes[bnd.cnt[SLOT_W-1:0]] = CH_NL;
					bnd.cnt = bnd.cnt + 1'b1;
				end
			end
			default: begin
				if (body.has_byte) begin
					bnd.bytes[0] = body.in_byte;
					bnd.cnt      = CNT_W'(1);
				end
			end
		endcase
	end

	assign push   = accept && (bnd.cnt != '0);
	assign bundle = bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PASS;
			quad_q  <= '0;
			accum_q <= '0;
			pad_q   <= '0;
			phase_q <= PH_IDLE;
			hi_q    <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (accept) begin
				quad_q  <= quad_d;
				accum_q <= accum_d;
				pad_q   <= pad_d;
				phase_q <= phase_d;
				hi_q    <= hi_d;
			end
		end
	end

endmodule

FILE: hw/rtl/mtd_queue.sv
module mtd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mtd_pkg::bundle_t bundle,
	output logic             full,
	input  logic             pop,
	output mtd_pkg::head_t   head
);
	import mtd_pkg::*;

	bundle_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_pop;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.item  = mem_q[rd_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/mtd_back.sv
module mtd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  mtd_pkg::head_t head,
	output logic           pop,
	mtd_out_if.source      decoded
);
	import mtd_pkg::*;

	logic [SLOT_W-1:0] idx_q;
	logic              last;
	logic              fire;

	assign last                = ({1'b0, idx_q} == (head.item.cnt - 1'b1));
	assign fire                = decoded.valid && decoded.ready;
	assign pop                 = fire && last;
	assign decoded.valid       = head.valid;
	assign decoded.out_byte    = head.item.bytes[idx_q];
	assign decoded.last_of_run = last;
	assign decoded.end_of_body = last && head.item.fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= last ? '0 : idx_q + 1'b1;
		end
	end

endmodule

FILE: hw/rtl/mime_transfer_decoder.sv
// Channel   Dir  Payload                                 Handshake
// body      in   has_byte, in_byte[7:0], body_end        valid / ready
// decoded   out  out_byte[7:0], last_of_run, end_of_body valid / ready
// cfg       in   cfg_wdata[1:0] (decode_mode)            cfg_we
//
// The front takes one item per cycle and decodes it in that cycle into a bundle of up to four bytes.
// A four-entry bundle queue sets when the front stalls; the back sends one byte per ready cycle.
// Sustained input rate is one item per cycle while the output side keeps up with the bytes produced.
// Reset clears the mode to pass-through and all decoder state; no clearing pass is needed.
module mime_transfer_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	mtd_in_if.sink     body,
	mtd_out_if.source  decoded
);
	import mtd_pkg::*;

	logic    push;
	logic    full;
	logic    pop;
	bundle_t bundle;
	head_t   head;

	mtd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.body      (body),
		.full      (full),
		.push      (push),
		.bundle    (bundle)
	);

	mtd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.bundle (bundle),
		.full   (full),
		.pop    (pop),
		.head   (head)
	);

	mtd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.decoded (decoded)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("bundle written into a full queue");

	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid |-> (head.item.cnt != '0))
		else $error("empty bundle at queue head");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(decoded.valid && decoded.end_of_body) |-> decoded.last_of_run)
		else $error("end of body flagged on a byte that is not last of its run");

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (decoded.valid && decoded.last_of_run))
		else $error("bundle retired before its last byte was sent");

endmodule

FILE: bench/mtd_decode_checker.sv
`timescale 1ns / 100ps

module mtd_decode_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	mtd_in_if          body,
	mtd_out_if         decoded,
	output int         fail_count,
	output int         waiting,
	output int         checked
);
	import mtd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       eob;
	} dec_byte_t;

	dec_byte_t      expected_bytes[$];
	logic [7:0]     step_bytes[$];
	dec_byte_t      want;

	logic [1:0]     mode_q;
	logic [1:0]     quad_cnt;
	logic [17:0]    sext_acc;
	logic [1:0]     pad_cnt;
	logic [1:0]     qp_state;
	logic [7:0]     qp_hold;

	function automatic logic [3:0] nibble_val(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return c[3:0];
		end
		if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			return c[3:0] + 4'd9;
		end
		return 4'd0;
	endfunction

	function automatic logic [5:0] sextet(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5a) begin
			return 6'(c - 8'h41);
		end
		if (c >= 8'h61 && c <= 8'h7a) begin
			return 6'(c - 8'h47);
		end
		if (c >= 8'h30 && c <= 8'h39) begin
			return 6'(c + 8'h04);
		end
		if (c == CH_PLUS) begin
			return 6'd62;
		end
		if (c == CH_SLASH) begin
			return 6'd63;
		end
		return 6'd0;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [7:0] us_to_space(input logic [7:0] c);
		return (c == CH_US) ? CH_SP : c;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] exp_val);
		if (fail_count < 40) begin
			$display("%0t: decoded byte %0d, %s: got %02h, expected %02h",
				$realtime, checked, what, got, exp_val);
		end
		fail_count++;
	endtask

	task automatic decode_item(input logic has, input logic [7:0] c, input logic fin);
		logic [23:0] full;
		int n;
		dec_byte_t r;
		step_bytes.delete();
		if (has) begin
			if (mode_q == MODE_QP) begin
				if (qp_state == PH_EQ) begin
					if (c == CH_NL) begin
						qp_state = PH_IDLE;
					end else begin
						qp_hold = c;
						qp_state = PH_HI;
					end
				end else if (qp_state == PH_HI) begin
					step_bytes.push_back({nibble_val(qp_hold), nibble_val(c)});
					qp_state = PH_IDLE;
				end else if (c == CH_EQ) begin
					qp_state = PH_EQ;
				end else begin
					step_bytes.push_back(us_to_space(c));
				end
			end else if (mode_q == MODE_B64) begin
				if (quad_cnt != 2'd0 || !is_space(c)) begin
					if (quad_cnt != 2'd0 && c == CH_EQ) begin
						pad_cnt = pad_cnt + 2'd1;
					end
					if (quad_cnt != 2'd3) begin
						sext_acc = {sext_acc[11:0], sextet(c)};
						quad_cnt = quad_cnt + 2'd1;
					end else begin
						full = {sext_acc, sextet(c)};
						n = 3 - int'(pad_cnt);
						if (n >= 1) begin
							step_bytes.push_back(full[23:16]);
						end
						if (n >= 2) begin
							step_bytes.push_back(full[15:8]);
						end
						if (n >= 3) begin
							step_bytes.push_back(full[7:0]);
						end
						quad_cnt = 2'd0;
						sext_acc = '0;
						pad_cnt = 2'd0;
					end
				end
			end else begin
				step_bytes.push_back(c);
			end
		end
		if (fin) begin
			if (mode_q == MODE_QP) begin
				if (qp_state == PH_EQ) begin
					step_bytes.push_back(CH_EQ);
				end else if (qp_state == PH_HI) begin
					step_bytes.push_back(CH_EQ);
					step_bytes.push_back(us_to_space(qp_hold));
				end
				qp_state = PH_IDLE;
				qp_hold = 8'h00;
			end else if (mode_q == MODE_B64) begin
				quad_cnt = 2'd0;
				sext_acc = '0;
				pad_cnt = 2'd0;
				step_bytes.push_back(CH_NL);
			end
		end
		foreach (step_bytes[i]) begin
			r.data = step_bytes[i];
			r.last = (i == step_bytes.size() - 1);
			r.eob = r.last && fin;
			expected_bytes.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q = MODE_PASS;
			quad_cnt = 2'd0;
			sext_acc = '0;
			pad_cnt = 2'd0;
			qp_state = PH_IDLE;
			qp_hold = 8'h00;
			expected_bytes.delete();
			waiting = 0;
			fail_count = 0;
			checked = 0;
		end else begin
			if (body.valid && body.ready) begin
				decode_item(body.has_byte, body.in_byte, body.body_end);
			end
			if (decoded.valid && decoded.ready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch("nothing expected", decoded.out_byte, 8'h00);
				end else begin
					want = expected_bytes.pop_front();
					if (decoded.out_byte !== want.data) begin
						report_mismatch("out_byte", decoded.out_byte, want.data);
					end
					if (decoded.last_of_run !== want.last) begin
						report_mismatch("last_of_run", 8'(decoded.last_of_run), 8'(want.last));
					end
					if (decoded.end_of_body !== want.eob) begin
						report_mismatch("end_of_body", 8'(decoded.end_of_body), 8'(want.eob));
					end
				end
				checked++;
			end
			if (cfg_we) begin
				mode_q = cfg_wdata;
			end
			waiting = expected_bytes.size();
		end
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import mtd_pkg::*;

	localparam logic [1:0] MODE_SPARE  = 2'd3;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         DRAIN_WAIT  = 8;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;
	bit         stalls_on;
	int         fail_count;
	int         waiting;
	int         checked;
	int         bytes_sent;
	int         cycle_count;
	logic [7:0] body_chars[$];
	string      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	string      hexdig = "0123456789ABCDEFabcdef";

	mtd_in_if  body ();
	mtd_out_if decoded ();

	mime_transfer_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.body      (body),
		.decoded   (decoded)
	);

	mtd_decode_checker decode_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.body       (body),
		.decoded    (decoded),
		.fail_count (fail_count),
		.waiting    (waiting),
		.checked    (checked)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always begin
		@(posedge clk);
		if (stalls_on && $urandom_range(0, 5) == 0) begin
			decoded.ready <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		decoded.ready <= 1'b1;
	end

	task automatic send_item(input logic has, input logic [7:0] c, input logic fin);
		if (stalls_on && $urandom_range(0, 5) == 0) begin
			body.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		body.valid <= 1'b1;
		body.has_byte <= has;
		body.in_byte <= c;
		body.body_end <= fin;
		do @(posedge clk); while (!body.ready);
		if (has) begin
			bytes_sent++;
		end
	endtask

	task automatic drain;
		body.valid <= 1'b0;
		do @(negedge clk); while (waiting != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] m);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [1:0] m;
		int len;
		int npad;
		int k;
		int phase;
		bit split_end;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = MODE_PASS;
		body.valid = 1'b0;
		body.has_byte = 1'b0;
		body.in_byte = 8'h00;
		body.body_end = 1'b0;
		decoded.ready = 1'b0;
		stalls_on = 1'b1;
		bytes_sent = 0;
		cycle_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Pass-through straight out of reset, with empty and end-only items.
		send_item(1'b1, 8'h00, 1'b0);
		send_item(1'b1, 8'hff, 1'b0);
		send_item(1'b0, 8'h5a, 1'b0);
		send_item(1'b0, 8'ha5, 1'b1);
		send_item(1'b1, 8'h41, 1'b1);

		// Quoted-printable: hex escape, soft line break, underscore and dangling escapes.
		write_mode(MODE_QP);
		send_item(1'b1, CH_EQ, 1'b0);
		send_item(1'b1, 8'h34, 1'b0);
		send_item(1'b1, 8'h31, 1'b0);
		send_item(1'b1, CH_EQ, 1'b0);
		send_item(1'b1, CH_NL, 1'b0);
		send_item(1'b1, CH_US, 1'b0);
		send_item(1'b1, CH_EQ, 1'b0);
		send_item(1'b1, CH_US, 1'b1);
		send_item(1'b1, CH_EQ, 1'b0);
		send_item(1'b0, 8'h00, 1'b1);

		// Base64: leading pad sign, a quad split by a mode change, and a partial quad at the end.
		write_mode(MODE_B64);
		send_item(1'b1, CH_EQ, 1'b0);
		send_item(1'b1, 8'h41, 1'b0);
		send_item(1'b1, CH_EQ, 1'b0);
		send_item(1'b1, CH_EQ, 1'b0);
		send_item(1'b1, 8'h51, 1'b0);
		send_item(1'b1, 8'h55, 1'b0);
		write_mode(MODE_SPARE);
		send_item(1'b1, 8'h46, 1'b0);
		write_mode(MODE_B64);
		send_item(1'b1, 8'h80, 1'b0);
		send_item(1'b1, CH_SLASH, 1'b1);
		send_item(1'b1, 8'h51, 1'b1);

		for (phase = 0; bytes_sent < 185; phase++) begin
			if (bytes_sent > 150) begin
				stalls_on = 1'b0;
			end
			case (phase)
				0: m = MODE_B64;
				1: m = MODE_PASS;
				2: m = MODE_QP;
				3: m = MODE_SPARE;
				default: m = 2'($urandom_range(0, 3));
			endcase
			write_mode(m);
			repeat ($urandom_range(1, 3)) begin
				body_chars.delete();
				case (m)
					MODE_QP: begin
						len = $urandom_range(1, 10);
						repeat (len) begin
							case ($urandom_range(0, 9))
								0, 1, 2, 3: body_chars.push_back(8'($urandom_range(8'h21, 8'h7e)));
								4: body_chars.push_back(CH_US);
								5, 6: begin
									body_chars.push_back(CH_EQ);
									body_chars.push_back(hexdig[$urandom_range(0, 21)]);
									body_chars.push_back(hexdig[$urandom_range(0, 21)]);
								end
								7: begin
									body_chars.push_back(CH_EQ);
									body_chars.push_back(CH_NL);
								end
								8: begin
									body_chars.push_back(CH_EQ);
									body_chars.push_back(8'($urandom_range(0, 255)));
									body_chars.push_back(8'($urandom_range(0, 255)));
								end
								default: body_chars.push_back(8'($urandom_range(0, 255)));
							endcase
						end
						case ($urandom_range(0, 3))
							0: body_chars.push_back(CH_EQ);
							1: begin
								body_chars.push_back(CH_EQ);
								body_chars.push_back(8'($urandom_range(0, 255)));
							end
							default: ;
						endcase
					end
					MODE_B64: begin
						len = $urandom_range(1, 4);
						for (k = 0; k < len; k++) begin
							if ($urandom_range(0, 3) == 0) begin
								npad = $urandom_range(0, 5);
								body_chars.push_back((npad == 5) ? CH_SP : 8'(CH_TAB + npad));
							end
							npad = (k == len - 1) ? $urandom_range(0, 2) : 0;
							repeat (4 - npad) body_chars.push_back(alphabet[$urandom_range(0, 63)]);
							repeat (npad) body_chars.push_back(CH_EQ);
							if ($urandom_range(0, 9) == 0) begin
								body_chars[body_chars.size() - 1 - $urandom_range(0, 3)] =
									8'($urandom_range(0, 255));
							end
						end
						if ($urandom_range(0, 3) == 0) begin
							repeat ($urandom_range(1, 3)) begin
								body_chars.push_back(alphabet[$urandom_range(0, 63)]);
							end
						end
					end
					default: begin
						repeat ($urandom_range(1, 12)) body_chars.push_back(8'($urandom_range(0, 255)));
					end
				endcase
				split_end = ($urandom_range(0, 3) == 0);
				for (k = 0; k < body_chars.size(); k++) begin
					if ($urandom_range(0, 15) == 0) begin
						send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
					end
					send_item(1'b1, body_chars[k], !split_end && k == body_chars.size() - 1);
				end
				if (split_end) begin
					send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
				end
			end
		end
		drain();

		$display("Run covered %0d encoded bytes in %0d mode settings, all four modes among them.",
			bytes_sent, phase + 4);
		$display("%0d decoded bytes were compared with the prediction.", checked);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
